@@ rtl/quicksort_engine_top_assert.svh @@
// Assertion macros for the quicksort engine.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef QUICKSORT_ENGINE_TOP_ASSERT_SVH
`define QUICKSORT_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define QSE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define QSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/qse_pkg.sv @@
// Package of the quicksort engine: value width and sequencer state type.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package qse_pkg;

  // Width of one element and of one sorted result.
  localparam int unsigned VALUE_W = 32;

  // Sequencer states of the sort engine.
  typedef enum logic [3:0] {
    S_LOAD,
    S_POP,
    S_RANGE,
    S_PIVOT,
    S_SCAN_I,
    S_CMP_I,
    S_SCAN_J,
    S_CMP_J,
    S_DECIDE,
    S_WR2,
    S_PUSH_HI,
    S_PUSH_LO,
    S_EMIT_RD,
    S_EMIT_LD,
    S_EMIT_WAIT
  } qse_state_e;

endpackage

`default_nettype wire

@@ rtl/qse_if.sv @@
// Valid/ready channel interfaces of the quicksort engine (input and result).
// Depends on qse_pkg for the value width.
`default_nettype none

// Input channel: one element per beat, last closes the batch.
interface qse_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qse_pkg::VALUE_W-1:0]   value;
  logic                                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// Result channel: one sorted element per beat.
interface qse_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qse_pkg::VALUE_W-1:0]   sorted_value;
  logic                                 last_out;
  logic                                 overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/qse_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module qse_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/quicksort_engine_top.sv @@
// Quicksort engine top level: batch loader, quicksort sequencer, result emitter.
// Depends on qse_pkg, qse_in_if, qse_out_if, qse_ram and the assertion macros.
//
//   channel | dir | beat contents                       | handshake
//   --------+-----+-------------------------------------+------------
//   in_i    | in  | value (s32), last                   | valid/ready
//   out_o   | out | sorted_value (s32), last_out, overflow | valid/ready
//
// Loading accepts one element per cycle. The sort then runs in place: each compare
// reads an element through the element RAM read port, each exchange makes two
// writes, and each range adds pop, pivot fetch, pivot placement and pushes.
// Emission reads each element, loads the output register and holds it through any
// output stall until the beat is taken, one result at a time. Reset clears all
// control state, the RAMs need no clearing, and in_i.ready is high only while loading.
`default_nettype none

module quicksort_engine_top #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qse_in_if.sink     in_i,
  qse_out_if.source  out_o
);

`include "quicksort_engine_top_assert.svh"

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = IW + 1;
  localparam int unsigned SW    = 2 * IW;
  localparam int unsigned VW    = qse_pkg::VALUE_W;
  localparam int unsigned SpMax = DEPTH / 2;

  // Control state.
  qse_pkg::qse_state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [IW-1:0] lo_q, lo_d;
  logic [IW-1:0] hi_q, hi_d;
  logic [CW-1:0] i_q, i_d;
  logic [IW-1:0] j_q, j_d;
  logic [IW-1:0] k_q, k_d;
  logic          fin_q, fin_d;
  logic          out_valid_q, out_valid_d;

  // Payload state.
  logic signed [VW-1:0] piv_q, piv_d;
  logic signed [VW-1:0] ai_q, ai_d;
  logic signed [VW-1:0] aj_q, aj_d;
  logic [IW-1:0]        w2a_q, w2a_d;
  logic signed [VW-1:0] w2d_q, w2d_d;
  logic signed [VW-1:0] out_val_q, out_val_d;
  logic                 out_last_q, out_last_d;
  logic                 out_ovf_q, out_ovf_d;

  // Element RAM and range stack RAM ports.
  logic                 st_we;
  logic [IW-1:0]        st_waddr;
  logic [VW-1:0]        st_wdata;
  logic [IW-1:0]        st_raddr;
  logic [VW-1:0]        st_rdata_raw;
  logic signed [VW-1:0] st_rdata;
  logic                 sk_we;
  logic [IW-1:0]        sk_waddr;
  logic [SW-1:0]        sk_wdata;
  logic [IW-1:0]        sk_raddr;
  logic [SW-1:0]        sk_rdata;

  // Helpers.
  logic          in_beat;
  logic [CW-1:0] n_new;
  logic [CW-1:0] sp_dec;
  logic [CW-1:0] lo_ext, hi_ext, j_ext, k_ext;
  logic [IW-1:0] sk_lo, sk_hi;

  // Conditions watched by the assertions.
  logic          in_scan, scan_ok, out_in_batch, final_beat, batch_clear;

  qse_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata_raw)
  );

  qse_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  assign st_rdata = $signed(st_rdata_raw);
  assign in_beat  = in_i.valid & in_i.ready;
  assign sp_dec   = sp_q - CW'(1);
  assign lo_ext   = {1'b0, lo_q};
  assign hi_ext   = {1'b0, hi_q};
  assign j_ext    = {1'b0, j_q};
  assign k_ext    = {1'b0, k_q};
  assign sk_lo    = sk_rdata[SW-1:IW];
  assign sk_hi    = sk_rdata[IW-1:0];

  // Batch size after the current input beat is taken.
  assign n_new = (count_q < CW'(DEPTH)) ? (count_q + CW'(1)) : count_q;

  // Channel outputs come straight from registers.
  assign in_i.ready         = (state_q == qse_pkg::S_LOAD);
  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_val_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.overflow     = out_ovf_q;

  // Sequencer: next state, RAM accesses and register updates.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    sp_d        = sp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    piv_d       = piv_q;
    ai_d        = ai_q;
    aj_d        = aj_q;
    w2a_d       = w2a_q;
    w2d_d       = w2d_q;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    st_we    = 1'b0;
    st_waddr = count_q[IW-1:0];
    st_wdata = in_i.value;
    st_raddr = '0;
    sk_we    = 1'b0;
    sk_waddr = sp_q[IW-1:0];
    sk_wdata = '0;
    sk_raddr = sp_dec[IW-1:0];

    case (state_q)
      // Store incoming elements; the last one starts the sort, or the emission when fewer than two are stored.
      qse_pkg::S_LOAD: begin
        if (in_beat) begin
          if (count_q < CW'(DEPTH)) begin
            st_we = 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          count_d = n_new;
          if (in_i.last) begin
            k_d = '0;
            if (n_new >= CW'(2)) begin
              sk_we    = 1'b1;
              sk_waddr = '0;
              sk_wdata = {IW'(0), n_new[IW-1:0] - IW'(1)};
              sp_d     = CW'(1);
              state_d  = qse_pkg::S_POP;
            end else begin
              state_d = qse_pkg::S_EMIT_RD;
            end
          end
        end
      end

      // Take the next range off the stack, or finish the sort.
      qse_pkg::S_POP: begin
        if (sp_q == '0) begin
          state_d = qse_pkg::S_EMIT_RD;
        end else begin
          sp_d    = sp_dec;
          state_d = qse_pkg::S_RANGE;
        end
      end

      // Range bounds arrive; fetch the pivot at its first element.
      qse_pkg::S_RANGE: begin
        lo_d     = sk_lo;
        hi_d     = sk_hi;
        i_d      = {1'b0, sk_lo} + CW'(1);
        j_d      = sk_hi;
        st_raddr = sk_lo;
        state_d  = qse_pkg::S_PIVOT;
      end

      qse_pkg::S_PIVOT: begin
        piv_d   = st_rdata;
        state_d = qse_pkg::S_SCAN_I;
      end

      // Left scan: skip elements not above the pivot.
      qse_pkg::S_SCAN_I: begin
        if (i_q <= hi_ext) begin
          st_raddr = i_q[IW-1:0];
          state_d  = qse_pkg::S_CMP_I;
        end else begin
          state_d = qse_pkg::S_SCAN_J;
        end
      end

      qse_pkg::S_CMP_I: begin
        if (st_rdata <= piv_q) begin
          i_d     = i_q + CW'(1);
          state_d = qse_pkg::S_SCAN_I;
        end else begin
          ai_d    = st_rdata;
          state_d = qse_pkg::S_SCAN_J;
        end
      end

      // Right scan: skip elements not below the pivot.
      qse_pkg::S_SCAN_J: begin
        if (j_q > lo_q) begin
          st_raddr = j_q;
          state_d  = qse_pkg::S_CMP_J;
        end else begin
          state_d = qse_pkg::S_DECIDE;
        end
      end

      qse_pkg::S_CMP_J: begin
        if (st_rdata >= piv_q) begin
          j_d     = j_q - IW'(1);
          state_d = qse_pkg::S_SCAN_J;
        end else begin
          aj_d    = st_rdata;
          state_d = qse_pkg::S_DECIDE;
        end
      end

      // First write of an exchange. When the scans crossed, the pivot moves to
      // j; when j stopped at the pivot itself, the second write restores it.
      qse_pkg::S_DECIDE: begin
        st_we    = 1'b1;
        st_wdata = aj_q;
        if (i_q > j_ext) begin
          st_waddr = lo_q;
          w2a_d    = j_q;
          w2d_d    = piv_q;
          fin_d    = 1'b1;
        end else begin
          st_waddr = i_q[IW-1:0];
          w2a_d    = j_q;
          w2d_d    = ai_q;
          fin_d    = 1'b0;
        end
        state_d = qse_pkg::S_WR2;
      end

      // Second write of the exchange, then continue or close the partition.
      qse_pkg::S_WR2: begin
        st_we    = 1'b1;
        st_waddr = w2a_q;
        st_wdata = w2d_q;
        state_d  = fin_q ? qse_pkg::S_PUSH_HI : qse_pkg::S_SCAN_I;
      end

      // Push the upper part, then the lower part, if they hold two or more.
      qse_pkg::S_PUSH_HI: begin
        if (((j_ext + CW'(1)) < hi_ext) && (sp_q < CW'(DEPTH))) begin
          sk_we    = 1'b1;
          sk_wdata = {j_q + IW'(1), hi_q};
          sp_d     = sp_q + CW'(1);
        end
        state_d = qse_pkg::S_PUSH_LO;
      end

      qse_pkg::S_PUSH_LO: begin
        if (((lo_ext + CW'(1)) < j_ext) && (sp_q < CW'(DEPTH))) begin
          sk_we    = 1'b1;
          sk_wdata = {lo_q, j_q - IW'(1)};
          sp_d     = sp_q + CW'(1);
        end
        state_d = qse_pkg::S_POP;
      end

      // Emission: read element k, load the output register, wait for the beat.
      qse_pkg::S_EMIT_RD: begin
        st_raddr = k_q;
        state_d  = qse_pkg::S_EMIT_LD;
      end

      qse_pkg::S_EMIT_LD: begin
        out_val_d   = st_rdata;
        out_last_d  = ((k_ext + CW'(1)) == count_q);
        out_ovf_d   = ovf_q;
        out_valid_d = 1'b1;
        state_d     = qse_pkg::S_EMIT_WAIT;
      end

      qse_pkg::S_EMIT_WAIT: begin
        if (out_o.ready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = qse_pkg::S_LOAD;
          end else begin
            k_d     = k_q + IW'(1);
            state_d = qse_pkg::S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = qse_pkg::S_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qse_pkg::S_LOAD;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      sp_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      sp_q        <= sp_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    piv_q      <= piv_d;
    ai_q       <= ai_d;
    aj_q       <= aj_d;
    w2a_q      <= w2a_d;
    w2d_q      <= w2d_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  // Conditions for the checks below.
  assign in_scan      = (state_q == qse_pkg::S_SCAN_I) || (state_q == qse_pkg::S_SCAN_J);
  assign scan_ok      = (i_q <= (hi_ext + CW'(1))) && (j_q >= lo_q) && (j_q <= hi_q);
  assign out_in_batch = (state_q == qse_pkg::S_EMIT_WAIT) && (k_ext < count_q);
  assign final_beat   = out_valid_q && out_o.ready && out_last_q;
  assign batch_clear  = (state_q == qse_pkg::S_LOAD) && (count_q == '0) && !ovf_q;

  // Pending ranges are disjoint and hold two or more elements each, so the stack never holds more than DEPTH/2.
  `QSE_ASSERT_IMPLIES(a_stack_bound, 1'b1, sp_q <= CW'(SpMax), "range stack too deep")

  // A result beat only shows an element inside the loaded batch.
  `QSE_ASSERT_IMPLIES(a_out_index, out_valid_q, out_in_batch, "result beat outside the batch")

  // The final result beat leaves an empty batch with overflow cleared.
  `QSE_ASSERT_NEXT(a_batch_close, final_beat, batch_clear, "batch not cleared after final beat")

  // Scan indices stay within the current range; i may run at most one past its end.
  `QSE_ASSERT_IMPLIES(a_scan_bounds, in_scan, scan_ok, "scan index left its range")

endmodule

`default_nettype wire

@@ bench/quicksort_engine_checker.sv @@
`timescale 1ns / 100ps
// Checker for the quicksort engine: watches both channels, predicts each sorted batch
// and compares every result beat. Depends on qse_pkg and the qse_in_if/qse_out_if channels.

module quicksort_engine_checker #(
  parameter int unsigned DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qse_in_if         in_mon,
  qse_out_if        out_mon,
  output int        err_count_o,
  output int        pending_o,
  output int        batches_o,
  output int        ovf_batches_o,
  output int        beats_o
);

  localparam int unsigned W = qse_pkg::VALUE_W;

  // One expected result beat.
  typedef struct packed {
    logic signed [W-1:0] value;
    logic                last;
    logic                ovf;
  } sort_beat_t;

  // Shadow copy of the batch being loaded and of the range stack used to sort it.
  logic signed [W-1:0] batch_mem [DEPTH];
  logic [11:0]         range_stk [DEPTH];
  int unsigned         batch_len;
  bit                  batch_ovf;
  int unsigned         stk_ptr;
  sort_beat_t          expected_q[$];
  int                  err_count;
  int                  batch_total;
  int                  ovf_total;
  int                  beat_total;

  initial begin
    batch_len   = 0;
    batch_ovf   = 1'b0;
    err_count   = 0;
    batch_total = 0;
    ovf_total   = 0;
    beat_total  = 0;
    err_count_o   = 0;
    pending_o     = 0;
    batches_o     = 0;
    ovf_batches_o = 0;
    beats_o       = 0;
  end

  // Pushes an index range unless it is trivial or the stack is full.
  function automatic void store_range(int lo, int hi);
    if (lo >= hi || stk_ptr >= DEPTH) return;
    range_stk[stk_ptr] = {lo[5:0], hi[5:0]};
    stk_ptr++;
  endfunction

  function automatic void swap_entries(int a, int b);
    logic signed [W-1:0] tmp;
    tmp = batch_mem[a[5:0]];
    batch_mem[a[5:0]] = batch_mem[b[5:0]];
    batch_mem[b[5:0]] = tmp;
  endfunction

  // In-place quicksort with the first element of each range as pivot.
  function automatic void quicksort_batch(int unsigned n);
    int          lo;
    int          hi;
    int          i;
    int          j;
    logic [11:0] rng;
    stk_ptr = 0;
    if (n < 2) return;
    store_range(0, n - 1);
    while (stk_ptr > 0) begin
      stk_ptr--;
      rng = range_stk[stk_ptr];
      lo  = int'(rng[11:6]);
      hi  = int'(rng[5:0]);
      i   = lo + 1;
      j   = hi;
      while (i <= j) begin
        while (i <= hi && batch_mem[i] <= batch_mem[lo]) i++;
        while (j > lo && batch_mem[j] >= batch_mem[lo]) j--;
        if (i > j) swap_entries(lo, j);
        else swap_entries(i, j);
      end
      store_range(j + 1, hi);
      store_range(lo, j - 1);
    end
  endfunction

  // Takes one accepted element; a closing element yields the whole sorted batch.
  function automatic void accept_element(logic signed [W-1:0] value, logic last);
    sort_beat_t beat;
    if (batch_len < DEPTH) begin
      batch_mem[batch_len] = value;
      batch_len++;
    end else begin
      batch_ovf = 1'b1;
    end
    if (!last) return;
    quicksort_batch(batch_len);
    for (int unsigned k = 0; k < batch_len; k++) begin
      beat.value = batch_mem[k];
      beat.last  = (k + 1 == batch_len);
      beat.ovf   = batch_ovf;
      expected_q.push_back(beat);
    end
    batch_total++;
    if (batch_ovf) ovf_total++;
    batch_len = 0;
    batch_ovf = 1'b0;
  endfunction

  function automatic void note_failure(string what);
    if (err_count < 10) $display("[%0t] MISMATCH: %s", $realtime, what);
    err_count++;
  endfunction

  // Result beats are checked before a same-cycle input beat adds a new batch.
  always @(posedge clk_i) begin
    sort_beat_t exp_beat;
    bit         bad;
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) begin
        beat_total++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected beat value %0d last %0b overflow %0b",
                                 out_mon.sorted_value, out_mon.last_out, out_mon.overflow));
        end else begin
          exp_beat = expected_q.pop_front();
          bad = 1'b0;
          if (out_mon.sorted_value !== exp_beat.value) bad = 1'b1;
          if (out_mon.last_out !== exp_beat.last) bad = 1'b1;
          if (out_mon.overflow !== exp_beat.ovf) bad = 1'b1;
          if (bad)
            note_failure($sformatf(
              "beat %0d expected value %0d last %0b overflow %0b, got %0d %0b %0b",
              beat_total, exp_beat.value, exp_beat.last, exp_beat.ovf,
              out_mon.sorted_value, out_mon.last_out, out_mon.overflow));
        end
      end
      if (in_mon.valid && in_mon.ready) accept_element(in_mon.value, in_mon.last);
    end
    err_count_o   <= err_count;
    pending_o     <= expected_q.size();
    batches_o     <= batch_total;
    ovf_batches_o <= ovf_total;
    beats_o       <= beat_total;
  end

endmodule

@@ bench/quicksort_engine_top_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the quicksort engine: clock, reset, batch stimulus and verdict.
// Depends on qse_pkg, the channel interfaces, quicksort_engine_top and the checker.

module quicksort_engine_top_tb;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned W     = qse_pkg::VALUE_W;
  localparam logic signed [W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

  // Shapes of the values inside one batch.
  typedef enum int {
    PAT_RANDOM,
    PAT_NARROW,
    PAT_ASCEND,
    PAT_DESCEND,
    PAT_EXTREME,
    PAT_CONSTANT
  } value_pattern_e;

  logic clk;
  logic rst_n;
  int   sort_errors;
  int   pending;
  int   batches;
  int   ovf_batches;
  int   beats;
  int   items_sent;
  int   send_calm;
  int   recv_calm;

  qse_in_if  in_ch ();
  qse_out_if out_ch ();

  quicksort_engine_top #(.DEPTH(DEPTH)) uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  quicksort_engine_checker #(.DEPTH(DEPTH)) sort_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .err_count_o   (sort_errors),
    .pending_o     (pending),
    .batches_o     (batches),
    .ovf_batches_o (ovf_batches),
    .beats_o       (beats)
  );

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Hard stop in case the engine hangs.
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Draws a random idle gap, with occasional stretches of none.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 11);
  endfunction

  // Sends one element beat after a random gap and waits for it to be taken.
  task automatic send_item(logic signed [W-1:0] value, logic last);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // Holds off the sender until every predicted result beat has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] pick_value(value_pattern_e pat, int idx,
                                                     logic signed [W-1:0] base, int step);
    case (pat)
      PAT_NARROW:   return $urandom_range(0, 6) - 3;
      PAT_ASCEND:   return base + idx * step;
      PAT_DESCEND:  return base - idx * step;
      PAT_EXTREME: begin
        case ($urandom_range(0, 6))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return 0;
          3:       return -1;
          4:       return 1;
          5:       return VAL_MIN + 1;
          default: return VAL_MAX - 1;
        endcase
      end
      PAT_CONSTANT: return base;
      default:      return $urandom();
    endcase
  endfunction

  // One batch of n elements; the closing beat carries last.
  task automatic run_batch(int n, value_pattern_e pat);
    logic signed [W-1:0] base;
    int                  step;
    base = $urandom();
    step = $urandom_range(1, 1000);
    for (int idx = 0; idx < n; idx++) send_item(pick_value(pat, idx, base, step), idx == n - 1);
  endtask

  function automatic value_pattern_e draw_pattern();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return PAT_RANDOM;
    if (r < 55) return PAT_NARROW;
    if (r < 67) return PAT_ASCEND;
    if (r < 79) return PAT_DESCEND;
    if (r < 90) return PAT_EXTREME;
    return PAT_CONSTANT;
  endfunction

  // Result side: ready drops for random stalls between beats.
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    recv_calm = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Stimulus: directed batches, then random batches of mixed sizes and shapes.
  initial begin : stimulus
    int rand_items;
    int n;
    int r;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    rst_n       <= 1'b0;
    items_sent  = 0;
    send_calm   = 0;
    rand_items  = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Single-element batches at both ends of the range.
    send_item(VAL_MIN, 1'b1);
    send_item(VAL_MAX, 1'b1);
    // Extremes, duplicates and alternating bit patterns in one batch.
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(VAL_MAX, 1'b0);
    send_item(VAL_MIN, 1'b0);
    send_item(1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shAAAA_AAAA, 1'b0);
    send_item(-1, 1'b0);
    send_item(0, 1'b0);
    send_item(VAL_MAX, 1'b1);
    // Two equal elements, then an already sorted and a reversed batch.
    send_item(5, 1'b0);
    send_item(5, 1'b1);
    send_item(-2, 1'b0);
    send_item(0, 1'b0);
    send_item(3, 1'b1);
    send_item(9, 1'b0);
    send_item(4, 1'b0);
    send_item(0, 1'b0);
    send_item(-7, 1'b1);
    wait_drained();

    // Random batches: mostly short, some filling the store, a few overrunning it.
    while (rand_items < 470) begin
      r = $urandom_range(0, 99);
      if (r < 6) n = $urandom_range(DEPTH + 1, DEPTH + 8);
      else if (r < 14) n = DEPTH;
      else if (r < 30) n = $urandom_range(17, DEPTH - 1);
      else n = $urandom_range(1, 16);
      run_batch(n, draw_pattern());
      rand_items += n;
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sorted %0d batches from %0d elements (%0d overran the store), %0d beats checked.",
             batches, items_sent, ovf_batches, beats);
    if (sort_errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("Failures: %0d mismatching beats, %0d results missing.", sort_errors, pending);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/qse_pkg.sv
rtl/qse_if.sv
rtl/qse_ram.sv
rtl/quicksort_engine_top.sv
bench/quicksort_engine_checker.sv
bench/quicksort_engine_top_tb.sv
